// ===== rtl/prdg_pkg.sv =====
// prdg_pkg: widths, register codes and shared types of the pinhole ray generator.
// No dependencies; every rtl file but prdg_chk imports it.
package prdg_pkg;

  localparam int MAX_DIM  = 4096;             // largest usable image dimension
  localparam int DIM_W    = 13;               // image dimension register
  localparam int PIX_W    = 12;               // pixel coordinate
  localparam int FRAC_W   = 16;               // Q0.16 sample fraction
  localparam int Q_W      = PIX_W + FRAC_W;   // sample quotient
  localparam int DIV_BITS = 4;                // quotient bits per divider stage
  localparam int DIV_STG  = Q_W / DIV_BITS;
  localparam int HALF     = 32768;            // 0.5 in Q0.16
  localparam int NUDGE    = 7;                // center-pixel nudge, ~0.0001
  localparam int H_W      = 30;               // centered sample
  localparam int PU_W     = H_W + 17;         // sample times sensor size
  localparam int CU_W     = PU_W - 8;
  localparam int PR_W     = CU_W + 16;
  localparam int PF_W     = 33;               // focal times forward
  localparam int C_W      = 56;               // raw direction component
  localparam int PS_W     = $clog2(C_W);
  localparam int TOP_BIT  = 29;               // msb target after scaling
  localparam int CS_W     = TOP_BIT + 2;      // scaled component, signed
  localparam int A_W      = CS_W;             // its magnitude
  localparam int SQ_W     = 62;               // sum of squares
  localparam int NR_W     = 64;               // root datapath
  localparam int SQ_ITER  = 2;
  localparam int SQ_STG   = (SQ_W / 2 + 1) / SQ_ITER;
  localparam int LEN_W    = 32;
  localparam int DIR_FRAC = 14;
  localparam int QD_BITS  = DIR_FRAC + 1;
  localparam int QD_PER   = 3;
  localparam int QD_STG   = QD_BITS / QD_PER;
  localparam int RW       = A_W + DIR_FRAC + 1;
  localparam int DV_W     = RW + 2;
  localparam int DIR_W    = 16;
  localparam int NEAR_W   = 24;
  localparam int POS_W    = 20;
  localparam int PRD_W    = NEAR_W + 1 + DIR_W;
  localparam int ORG_W    = 20;
  localparam int AX_W     = 16;
  localparam int CFG_W    = 60;
  localparam int NSTG     = DIV_STG + 3 + 5 + SQ_STG + QD_STG + 1;

  typedef enum logic [2:0] {
    REG_WIDTH,
    REG_HEIGHT,
    REG_FORWARD,
    REG_RIGHT,
    REG_UP,
    REG_EYE,
    REG_LENS,
    REG_CLIP
  } reg_idx_e;

  typedef struct packed {
    logic [DIM_W-1:0]           wdim;
    logic [DIM_W-1:0]           hdim;
    logic [2:0][AX_W-1:0]       fwd;
    logic [2:0][AX_W-1:0]       rgt;
    logic [2:0][AX_W-1:0]       upv;
    logic [2:0][POS_W-1:0]      eye;
    logic [15:0]                sens_w;
    logic [15:0]                sens_h;
    logic [15:0]                focal;
    logic [NEAR_W-1:0]          near_d;
    logic [NEAR_W-1:0]          far_d;
  } cfg_t;

  typedef struct packed {
    logic [2:0][A_W-1:0] mag;
    logic [2:0]          neg;
    logic                zero;
  } vec_t;

  typedef struct packed {
    logic [2:0][DIR_W-1:0] dir;
    logic [2:0][ORG_W-1:0] org;
    logic [NEAR_W-1:0]     span;
  } res_t;

endpackage

// ===== rtl/prdg_samp.sv =====
// prdg_samp: pixel-to-sample dividers, centering, sensor scaling and the
// raw direction components. Depends on prdg_pkg.
module prdg_samp
  import prdg_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  en_i,
  input  cfg_t                  cfg_i,
  input  logic [PIX_W-1:0]      pixel_x_i,
  input  logic [PIX_W-1:0]      pixel_y_i,
  output logic [2:0][C_W-1:0]   comp_o
);

  function automatic logic [DIM_W+Q_W-1:0] div_step(input logic [DIM_W-1:0] rem,
                                                    input logic [Q_W-1:0]   quo,
                                                    input logic             nb,
                                                    input logic [DIM_W-1:0] dvs);
    logic [DIM_W:0] trial;
    trial = {rem, nb};
    if (trial >= {1'b0, dvs}) begin
      return {DIM_W'(trial - {1'b0, dvs}), quo[Q_W-2:0], 1'b1};
    end
    return {trial[DIM_W-1:0], quo[Q_W-2:0], 1'b0};
  endfunction

  logic [1:0][DIM_W-1:0] dvs;
  logic [1:0][PIX_W-1:0] px_q  [DIV_STG];
  logic [1:0][DIM_W-1:0] rem_q [DIV_STG];
  logic [1:0][Q_W-1:0]   quo_q [DIV_STG];

  assign dvs = {cfg_i.hdim, cfg_i.wdim};

  // lane 0 is u (x / width), lane 1 is v (y / height)
  for (genvar s = 0; s < DIV_STG; s++) begin : g_div
    logic [1:0][PIX_W-1:0] px_in;
    logic [1:0][DIM_W-1:0] rem_in, rem_d;
    logic [1:0][Q_W-1:0]   quo_in, quo_d;

    if (s == 0) begin : g_first
      assign px_in  = {pixel_y_i, pixel_x_i};
      assign rem_in = '0;
      assign quo_in = '0;
    end else begin : g_next
      assign px_in  = px_q[s-1];
      assign rem_in = rem_q[s-1];
      assign quo_in = quo_q[s-1];
    end

    always_comb begin : c_step
      logic [Q_W-1:0] dvd;
      rem_d = rem_in;
      quo_d = quo_in;
      for (int l = 0; l < 2; l++) begin
        dvd = {px_in[l], {FRAC_W{1'b0}}};
        for (int j = 0; j < DIV_BITS; j++) begin
          {rem_d[l], quo_d[l]} = div_step(rem_d[l], quo_d[l],
                                          dvd[Q_W-1-(s*DIV_BITS+j)], dvs[l]);
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        px_q[s]  <= px_in;
        rem_q[s] <= rem_d;
        quo_q[s] <= quo_d;
      end
    end
  end

  // centering and sensor scale
  logic [Q_W-1:0]          smp  [2];
  logic signed [H_W-1:0]   hu   [2];
  logic signed [16:0]      sens [2];
  logic signed [PU_W-1:0]  pu_d [2];
  logic signed [PU_W-1:0]  pu_q [2];

  assign sens[0] = $signed({1'b0, cfg_i.sens_w});
  assign sens[1] = $signed({1'b0, cfg_i.sens_h});

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      smp[l] = quo_q[DIV_STG-1][l] +
               (({px_q[DIV_STG-1][l], 1'b0} == dvs[l]) ? Q_W'(NUDGE) : Q_W'(0));
      hu[l]   = $signed({{(H_W-Q_W){1'b0}}, smp[l]}) - H_W'(HALF);
      pu_d[l] = hu[l] * sens[l];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pu_q <= pu_d;
    end
  end

  // basis products
  logic signed [CU_W-1:0] cu, cv;
  logic signed [16:0]     focal_s;
  logic signed [PR_W-1:0] pr_d [3], pr_q [3], pq_d [3], pq_q [3];
  logic signed [PF_W-1:0] pf_d [3], pf_q [3];

  assign cu      = pu_q[0][PU_W-1:8];
  assign cv      = pu_q[1][PU_W-1:8];
  assign focal_s = $signed({1'b0, cfg_i.focal});

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      pr_d[i] = cu * $signed(cfg_i.rgt[i]);
      pq_d[i] = cv * $signed(cfg_i.upv[i]);
      pf_d[i] = focal_s * $signed(cfg_i.fwd[i]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pr_q <= pr_d;
      pq_q <= pq_d;
      pf_q <= pf_d;
    end
  end

  // component sums at Q.30
  logic signed [C_W-1:0] c_d [3], c_q [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      c_d[i] = (C_W'(pf_q[i]) <<< 8) + C_W'(pr_q[i]) + C_W'(pq_q[i]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      c_q <= c_d;
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      comp_o[i] = c_q[i];
    end
  end

endmodule

// ===== rtl/prdg_norm.sv =====
// prdg_norm: power-of-two scaling of the raw direction, magnitudes and the
// sum of squares. Depends on prdg_pkg.
module prdg_norm
  import prdg_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 en_i,
  input  logic [2:0][C_W-1:0]  comp_i,
  output logic [SQ_W-1:0]      sum_o,
  output vec_t                 vec_o
);

  // stage A: OR of magnitudes has the same msb as the largest one
  logic signed [C_W-1:0] ca_q [3];
  logic [C_W-2:0]        orw_d, orw_q;
  logic [C_W-1:0]        absv;

  always_comb begin
    orw_d = '0;
    absv  = '0;
    for (int i = 0; i < 3; i++) begin
      absv  = comp_i[i][C_W-1] ? -comp_i[i] : comp_i[i];
      orw_d = orw_d | absv[C_W-2:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        ca_q[i] <= $signed(comp_i[i]);
      end
      orw_q <= orw_d;
    end
  end

  // stage B: leading one
  logic signed [C_W-1:0] cb_q [3];
  logic [PS_W-1:0]       pos_d, pos_q;
  logic                  zb_q;

  always_comb begin
    pos_d = '0;
    for (int b = 0; b < C_W - 1; b++) begin
      if (orw_q[b]) begin
        pos_d = PS_W'(b);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cb_q  <= ca_q;
      pos_q <= pos_d;
      zb_q  <= (orw_q == '0);
    end
  end

  // stage C: shift so the largest magnitude lands in [2^29, 2^30)
  logic signed [CS_W-1:0] cs_d [3], cs_q [3];
  logic                   zc_q;

  always_comb begin : c_shift
    logic signed [C_W-1:0] tmp;
    tmp = '0;
    for (int i = 0; i < 3; i++) begin
      if (pos_q > PS_W'(TOP_BIT)) begin
        tmp = cb_q[i] >>> (pos_q - PS_W'(TOP_BIT));   // floor shift
      end else begin
        tmp = cb_q[i] <<< (PS_W'(TOP_BIT) - pos_q);
      end
      cs_d[i] = tmp[CS_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cs_q <= cs_d;
      zc_q <= zb_q;
    end
  end

  // stage D: magnitudes and squares
  logic [A_W-1:0]  mag_d [3], mag_q [3];
  logic [SQ_W-1:0] sq_d [3], sq_q [3];
  logic [2:0]      neg_q;
  logic            zd_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mag_d[i] = cs_q[i][CS_W-1] ? A_W'(-cs_q[i]) : A_W'(cs_q[i]);
      sq_d[i]  = mag_d[i] * mag_d[i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mag_q <= mag_d;
      sq_q  <= sq_d;
      for (int i = 0; i < 3; i++) begin
        neg_q[i] <= cs_q[i][CS_W-1];
      end
      zd_q <= zc_q;
    end
  end

  // stage E: sum of squares
  logic [SQ_W-1:0] sum_q;
  vec_t            vec_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sum_q      <= sq_q[0] + sq_q[1] + sq_q[2];
      vec_q.neg  <= neg_q;
      vec_q.zero <= zd_q;
      for (int i = 0; i < 3; i++) begin
        vec_q.mag[i] <= mag_q[i];
      end
    end
  end

  assign sum_o = sum_q;
  assign vec_o = vec_q;

endmodule

// ===== rtl/prdg_sqrt.sv =====
// prdg_sqrt: pipelined integer square root, two result bits per stage.
// Depends on prdg_pkg.
module prdg_sqrt
  import prdg_pkg::*;
(
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [SQ_W-1:0]  sum_i,
  input  vec_t             vec_i,
  output logic [LEN_W-1:0] len_o,
  output vec_t             vec_o
);

  function automatic logic [2*NR_W-1:0] sqrt_step(input logic [NR_W-1:0] n,
                                                  input logic [NR_W-1:0] r,
                                                  input logic [NR_W-1:0] b);
    if (n >= r + b) begin
      return {n - (r + b), (r >> 1) + b};
    end
    return {n, r >> 1};
  endfunction

  logic [NR_W-1:0] n_q [SQ_STG];
  logic [NR_W-1:0] r_q [SQ_STG];
  vec_t            v_q [SQ_STG];

  for (genvar s = 0; s < SQ_STG; s++) begin : g_root
    logic [NR_W-1:0] n_in, r_in, n_d, r_d;
    vec_t            v_in;

    if (s == 0) begin : g_first
      assign n_in = NR_W'(sum_i);
      assign r_in = '0;
      assign v_in = vec_i;
    end else begin : g_next
      assign n_in = n_q[s-1];
      assign r_in = r_q[s-1];
      assign v_in = v_q[s-1];
    end

    always_comb begin
      n_d = n_in;
      r_d = r_in;
      for (int j = 0; j < SQ_ITER; j++) begin
        {n_d, r_d} = sqrt_step(n_d, r_d, NR_W'(1) << (SQ_W - 2 * (s * SQ_ITER + j)));
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        n_q[s] <= n_d;
        r_q[s] <= r_d;
        v_q[s] <= v_in;
      end
    end
  end

  assign len_o = r_q[SQ_STG-1][LEN_W-1:0];
  assign vec_o = v_q[SQ_STG-1];

endmodule

// ===== rtl/prdg_dirq.sv =====
// prdg_dirq: rounded division to unit direction, origin on the near plane
// and depth span. Depends on prdg_pkg.
module prdg_dirq
  import prdg_pkg::*;
(
  input  logic             clk_i,
  input  logic             en_i,
  input  cfg_t             cfg_i,
  input  logic [LEN_W-1:0] len_i,
  input  vec_t             vec_i,
  output res_t             res_o
);

  logic [2:0][RW-1:0]      rm_q  [QD_STG];
  logic [2:0][QD_BITS-1:0] qt_q  [QD_STG];
  logic [LEN_W-1:0]        len_q [QD_STG];
  vec_t                    v_q   [QD_STG];

  // restoring divide, quotient bits from msb down, three per stage
  for (genvar s = 0; s < QD_STG; s++) begin : g_quo
    logic [2:0][RW-1:0]      rm_in, rm_d;
    logic [2:0][QD_BITS-1:0] qt_in, qt_d;
    logic [LEN_W-1:0]        len_in;
    vec_t                    v_in;

    if (s == 0) begin : g_first
      always_comb begin
        for (int i = 0; i < 3; i++) begin
          // round half away: add len/2 before dividing the magnitude
          rm_in[i] = RW'({vec_i.mag[i], {DIR_FRAC{1'b0}}}) + RW'(len_i >> 1);
        end
      end
      assign qt_in  = '0;
      assign len_in = len_i;
      assign v_in   = vec_i;
    end else begin : g_next
      assign rm_in  = rm_q[s-1];
      assign qt_in  = qt_q[s-1];
      assign len_in = len_q[s-1];
      assign v_in   = v_q[s-1];
    end

    always_comb begin : c_step
      logic [DV_W-1:0] dv;
      rm_d = rm_in;
      qt_d = qt_in;
      dv   = '0;
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < QD_PER; j++) begin
          dv = DV_W'(len_in) << (QD_BITS - 1 - (s * QD_PER + j));
          if (DV_W'(rm_d[i]) >= dv) begin
            rm_d[i] = RW'(DV_W'(rm_d[i]) - dv);
            qt_d[i][QD_BITS-1-(s*QD_PER+j)] = 1'b1;
          end
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rm_q[s]  <= rm_d;
        qt_q[s]  <= qt_d;
        len_q[s] <= len_in;
        v_q[s]   <= v_in;
      end
    end
  end

  // signed direction and near-plane product
  logic signed [DIR_W-1:0] dir_d [3], dir_q [3];
  logic signed [PRD_W-1:0] prd_d [3], prd_q [3];
  logic signed [NEAR_W:0]  near_s;

  assign near_s = $signed({1'b0, cfg_i.near_d});

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (v_q[QD_STG-1].zero) begin
        dir_d[i] = '0;
      end else if (v_q[QD_STG-1].neg[i]) begin
        dir_d[i] = -$signed({1'b0, qt_q[QD_STG-1][i]});
      end else begin
        dir_d[i] = $signed({1'b0, qt_q[QD_STG-1][i]});
      end
      prd_d[i] = near_s * dir_d[i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dir_q <= dir_d;
      prd_q <= prd_d;
    end
  end

  // origin = eye + round(near * dir / 2^18), saturated
  localparam int RND_W = PRD_W + 1;
  localparam int OS_W  = RND_W - 18 + 1;

  logic signed [RND_W-1:0] rnd;
  logic signed [OS_W-1:0]  osum;

  always_comb begin
    res_o = '0;
    rnd   = '0;
    osum  = '0;
    for (int i = 0; i < 3; i++) begin
      rnd  = RND_W'(prd_q[i]) + RND_W'(1 << 17);
      osum = OS_W'($signed(rnd[RND_W-1:18])) + OS_W'($signed(cfg_i.eye[i]));
      if (osum > OS_W'(524287)) begin
        res_o.org[i] = {1'b0, {(ORG_W-1){1'b1}}};
      end else if (osum < -OS_W'(524288)) begin
        res_o.org[i] = {1'b1, {(ORG_W-1){1'b0}}};
      end else begin
        res_o.org[i] = osum[ORG_W-1:0];
      end
      res_o.dir[i] = dir_q[i];
    end
    res_o.span = (cfg_i.far_d > cfg_i.near_d) ? cfg_i.far_d - cfg_i.near_d : '0;
  end

endmodule

// ===== rtl/pinhole_depth_ray_generator.sv =====
// pinhole_depth_ray_generator: top level, configuration registers, valid pipeline
// and output register with skid. Depends on prdg_pkg and prdg_samp/norm/sqrt/dirq.
//
//  channel | handshake               | payload
//  --------+-------------------------+-------------------------------------------
//  in      | in_valid_i / in_stall_o | pixel_x_i, pixel_y_i
//  out     | out_valid_o/out_stall_i | dir_{x,y,z}_o, origin_{x,y,z}_o, depth_span_o
//  cfg     | cfg_we_i                | cfg_idx_i, cfg_data_i (write only)
//
// One request per clock sustained while the skid register is empty. The pipeline
// has NSTG stages plus the output register; among them are the sample
// dividers (7 stages), the square root (16) and the direction divide (5).
// Reset clears valid pipeline, output/skid flags, config registers (dims to 1) only.
// A stalled output holds; the next result lands in a skid register, and
// in_stall_o (registered) freezes the pipeline only while that skid is full.
module pinhole_depth_ray_generator
  import prdg_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  // configuration
  input  logic                     cfg_we_i,
  input  logic [2:0]               cfg_idx_i,
  input  logic [CFG_W-1:0]         cfg_data_i,
  // pixel requests
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic [PIX_W-1:0]         pixel_x_i,
  input  logic [PIX_W-1:0]         pixel_y_i,
  // ray results
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic signed [DIR_W-1:0]  dir_x_o,
  output logic signed [DIR_W-1:0]  dir_y_o,
  output logic signed [DIR_W-1:0]  dir_z_o,
  output logic signed [ORG_W-1:0]  origin_x_o,
  output logic signed [ORG_W-1:0]  origin_y_o,
  output logic signed [ORG_W-1:0]  origin_z_o,
  output logic [NEAR_W-1:0]        depth_span_o
);

  // ---------------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------------
  logic [DIM_W-1:0]    width_q, height_q;
  logic [3*AX_W-1:0]   fwd_q, rgt_q, upv_q, lens_q;
  logic [3*POS_W-1:0]  eye_q;
  logic [2*NEAR_W-1:0] clip_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= DIM_W'(1);
      height_q <= DIM_W'(1);
      fwd_q    <= '0;
      rgt_q    <= '0;
      upv_q    <= '0;
      eye_q    <= '0;
      lens_q   <= '0;
      clip_q   <= '0;
    end else if (cfg_we_i) begin
      case (reg_idx_e'(cfg_idx_i))
        REG_WIDTH:   width_q  <= cfg_data_i[DIM_W-1:0];
        REG_HEIGHT:  height_q <= cfg_data_i[DIM_W-1:0];
        REG_FORWARD: fwd_q    <= cfg_data_i[3*AX_W-1:0];
        REG_RIGHT:   rgt_q    <= cfg_data_i[3*AX_W-1:0];
        REG_UP:      upv_q    <= cfg_data_i[3*AX_W-1:0];
        REG_EYE:     eye_q    <= cfg_data_i[3*POS_W-1:0];
        REG_LENS:    lens_q   <= cfg_data_i[3*AX_W-1:0];
        REG_CLIP:    clip_q   <= cfg_data_i[2*NEAR_W-1:0];
        default: ;
      endcase
    end
  end

  // zero dimension acts as 1, large ones clamp to MAX_DIM
  function automatic logic [DIM_W-1:0] dim_of(input logic [DIM_W-1:0] v);
    if (v == '0) begin
      return DIM_W'(1);
    end
    if (int'(v) > MAX_DIM) begin
      return DIM_W'(MAX_DIM);
    end
    return v;
  endfunction

  cfg_t cfg;

  always_comb begin
    cfg.wdim   = dim_of(width_q);
    cfg.hdim   = dim_of(height_q);
    cfg.fwd    = fwd_q;
    cfg.rgt    = rgt_q;
    cfg.upv    = upv_q;
    cfg.eye    = eye_q;
    cfg.sens_w = lens_q[15:0];
    cfg.sens_h = lens_q[31:16];
    cfg.focal  = lens_q[47:32];
    cfg.near_d = clip_q[NEAR_W-1:0];
    cfg.far_d  = clip_q[2*NEAR_W-1:NEAR_W];
  end

  // ---------------------------------------------------------------------
  // pipeline control: every stage advances together unless skid is full
  // ---------------------------------------------------------------------
  logic            en;
  logic [NSTG-1:0] vld_q;
  logic            skid_v_q, out_v_q;

  assign en         = !skid_v_q;
  assign in_stall_o = skid_v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[NSTG-2:0], in_valid_i};
    end
  end

  // ---------------------------------------------------------------------
  // datapath
  // ---------------------------------------------------------------------
  logic [2:0][C_W-1:0] comp;
  logic [SQ_W-1:0]     sum;
  vec_t                nvec, rvec;
  logic [LEN_W-1:0]    len;
  res_t                res;

  prdg_samp u_samp (
    .clk_i     (clk_i),
    .en_i      (en),
    .cfg_i     (cfg),
    .pixel_x_i (pixel_x_i),
    .pixel_y_i (pixel_y_i),
    .comp_o    (comp)
  );

  prdg_norm u_norm (
    .clk_i  (clk_i),
    .en_i   (en),
    .comp_i (comp),
    .sum_o  (sum),
    .vec_o  (nvec)
  );

  prdg_sqrt u_sqrt (
    .clk_i (clk_i),
    .en_i  (en),
    .sum_i (sum),
    .vec_i (nvec),
    .len_o (len),
    .vec_o (rvec)
  );

  prdg_dirq u_dirq (
    .clk_i (clk_i),
    .en_i  (en),
    .cfg_i (cfg),
    .len_i (len),
    .vec_i (rvec),
    .res_o (res)
  );

  // ---------------------------------------------------------------------
  // output register and skid
  // ---------------------------------------------------------------------
  logic arrive, out_free;
  res_t out_q, skid_q;

  assign arrive   = vld_q[NSTG-1] && en;
  assign out_free = !out_v_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else begin
      if (out_free) begin
        out_v_q  <= skid_v_q || arrive;
        skid_v_q <= 1'b0;
      end else if (arrive) begin
        skid_v_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free) begin
      out_q <= skid_v_q ? skid_q : res;
    end
    if (!out_free && arrive) begin
      skid_q <= res;
    end
  end

  assign out_valid_o  = out_v_q;
  assign dir_x_o      = out_q.dir[0];
  assign dir_y_o      = out_q.dir[1];
  assign dir_z_o      = out_q.dir[2];
  assign origin_x_o   = out_q.org[0];
  assign origin_y_o   = out_q.org[1];
  assign origin_z_o   = out_q.org[2];
  assign depth_span_o = out_q.span;

endmodule

// ===== rtl/prdg_chk.sv =====
// prdg_chk: port-level checks for pinhole_depth_ray_generator, bound to it
// below. No package dependency.
module prdg_chk (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input logic signed [15:0] dir_x_o,
  input logic signed [15:0] dir_y_o,
  input logic signed [15:0] dir_z_o
);

  // held result stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(dir_x_o))
    else $error("stalled result changed");

  // skid only fills behind a held result
  a_stall_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled without a pending result");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(in_stall_o) |-> $past(out_valid_o && out_stall_i))
    else $error("input stall without downstream stall");

  // unit direction never exceeds 1.0 in Q1.14
  a_dir_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> dir_x_o >= -16'sd16384 && dir_x_o <= 16'sd16384 &&
                    dir_y_o >= -16'sd16384 && dir_y_o <= 16'sd16384 &&
                    dir_z_o >= -16'sd16384 && dir_z_o <= 16'sd16384)
    else $error("direction component out of range");

endmodule

bind pinhole_depth_ray_generator prdg_chk u_prdg_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .dir_x_o     (dir_x_o),
  .dir_y_o     (dir_y_o),
  .dir_z_o     (dir_z_o)
);
